### design/arfc_pkg.sv
`timescale 1ns / 1ps

package arfc_pkg;

  // Limit at which the character count saturates; the store holds VIEW_LEN entries.
  localparam int STORE_DEPTH = 32;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  // Only the leading characters up to offset 17 take part in classification.
  localparam int VIEW_LEN    = 18;
  localparam int TICK_W      = 24;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ERROR   = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_NOSIG   = 3'd4,
    ST_POOR    = 3'd5,
    ST_GOOD    = 3'd6,
    ST_GREAT   = 3'd7
  } status_t;

  typedef logic [VIEW_LEN-1:0][7:0] view_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        rx_byte;
    logic              mqtt_mode;
    logic [TICK_W-1:0] timeout_ticks;
  } item_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Classify a finished reply; positions past the reply must read as zero.
  function automatic status_t classify(input view_t v);
    status_t    st;
    logic [7:0] a;
    logic [7:0] b;
    a = v[6];
    b = v[7];
    if (v[0] == "+") begin
      if ({v[1], v[2], v[3], v[4]} == "CPIN") begin
        st = (v[7] == "R") ? ST_OK : ST_ERROR;
      end else if ({v[1], v[2], v[3], v[4]} == "CREG") begin
        st = (v[9] == "1") ? ST_OK : ST_ERROR;
      end else if (({v[1], v[2], v[3], v[4], v[5]} == "CGREG") ||
                   ({v[1], v[2], v[3], v[4], v[5]} == "CEREG")) begin
        st = (v[10] == "1") ? ST_OK : ST_ERROR;
      end else if ({v[1], v[2], v[3]} == "CSQ") begin
        if ((a == "9") && (b == "9")) begin
          st = ST_NOSIG;
        end else if ((a <= "1") && (b <= "7")) begin
          st = ST_POOR;
        end else if ((a >= "3") && (b >= "1")) begin
          st = ST_GREAT;
        end else begin
          st = ST_GOOD;
        end
      end else if ({v[1], v[2], v[3]} == "CME") begin
        st = ST_ERROR;
      end else if ({v[1], v[2], v[3], v[4], v[5], v[6], v[7]} == "QNWINFO") begin
        st = ST_OK;
      end else begin
        st = ST_UNKNOWN;
      end
    end else if ({v[2], v[3], v[4], v[5], v[6]} == " +QMT") begin
      if (({v[7], v[8], v[9], v[10]} == "OPEN") ||
          ({v[7], v[8], v[9], v[10]} == "DISC")) begin
        st = (v[15] == "0") ? ST_OK : ST_ERROR;
      end else if ({v[7], v[8], v[9], v[10]} == "CONN") begin
        st = (v[17] == "0") ? ST_OK : ST_ERROR;
      end else if (({v[7], v[8], v[9]} == "SUB") || ({v[7], v[8], v[9]} == "UNS") ||
                   ({v[7], v[8], v[9]} == "PUB")) begin
        st = (v[16] != "2") ? ST_OK : ST_ERROR;
      end else begin
        st = ST_UNKNOWN;
      end
    end else if (((v[0] == "O") && (v[1] == "K")) || ((v[0] == "A") && (v[1] == "T"))) begin
      st = ST_OK;
    end else if ((v[0] == "E") && (v[1] == "R")) begin
      st = ST_ERROR;
    end else if (is_digit(v[0]) && is_digit(v[1])) begin
      st = ST_OK;
    end else begin
      st = ST_UNKNOWN;
    end
    return st;
  endfunction

endpackage

### design/at_response_framer_classifier.sv
`timescale 1ns / 1ps

// AT reply framer and classifier. Send a start item (op 0) with the MQTT flag
// and a tick limit, then the modem's reply bytes (op 1) and millisecond ticks
// (op 2). CR and LF fold to a single space. When the reply ends (plain mode:
// "OK" or "OR" at the tail; MQTT mode: more than ten characters ending comma,
// character, space) one status item is produced from the stored text; if the
// tick after the limit arrives first, a timeout status is produced instead.
// Bytes and ticks while idle, and op 3, are dropped without a result; a start
// while busy restarts the reply. One item is accepted every cycle while
// in_ready is high: all framing and classification is fixed-offset compares
// between the reply registers and the result buffer; a status is registered
// into the head, or into the skid while the head is held. A two-entry result
// buffer lets input continue while a result waits; in_ready falls only when
// both entries are full. No clearing pass is needed after reset or on start.

module at_response_framer_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_mqtt_mode,
  input  logic [arfc_pkg::TICK_W-1:0]     in_timeout_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output arfc_pkg::status_t               out_status
);
  import arfc_pkg::*;

  logic    in_take;
  item_t   item;
  res_t    fr_res;

  // Result buffer: head register drives the port, skid holds a second item.
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  status_t skid_status_r, skid_status_nxt;
  logic    pop;

  assign in_ready = !skid_valid_r;
  assign in_take  = in_valid && in_ready;
  assign item     = '{op: in_op, rx_byte: in_rx_byte, mqtt_mode: in_mqtt_mode,
                      timeout_ticks: in_timeout_ticks};

  arfc_framer u_framer (
    .clk  (clk),
    .rst_n(rst_n),
    .take (in_take),
    .item (item),
    .res  (fr_res)
  );

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    skid_valid_nxt  = skid_valid_r;
    skid_status_nxt = skid_status_r;
    if (skid_valid_r) begin
      // Input is held off here, so only advance the skid into the head.
      if (pop) begin
        out_status_nxt = skid_status_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (fr_res.valid) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fr_res.status;
      end else begin
        skid_valid_nxt  = 1'b1;
        skid_status_nxt = fr_res.status;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    skid_status_r <= skid_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while the head is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && fr_res.valid && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("result lost while the output is stalled");

endmodule

### design/arfc_framer.sv
`timescale 1ns / 1ps

module arfc_framer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  arfc_pkg::item_t item,
  output arfc_pkg::res_t  res
);
  import arfc_pkg::*;

  logic              busy_r, busy_nxt;
  logic              mqtt_r, mqtt_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [23:0]       last_r, last_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0] limit_r, limit_nxt;
  view_t             store_r, store_nxt;

  logic              is_crlf;
  logic              keep;
  logic              wr_en;
  logic [7:0]        ch;
  logic              done;
  logic [CNT_W-1:0]  cnt_lim;
  view_t             view;

  always_comb begin
    busy_nxt    = busy_r;
    mqtt_nxt    = mqtt_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    elapsed_nxt = elapsed_r;
    limit_nxt   = limit_r;
    store_nxt   = store_r;
    res         = '{valid: 1'b0, status: ST_OK};

    is_crlf = (item.rx_byte == CHR_CR) || (item.rx_byte == CHR_LF);
    ch      = is_crlf ? CHR_SPACE : item.rx_byte;
    // Collapse CR/LF to one space, never at the start or after a space.
    keep    = !is_crlf || ((cnt_r != '0) && (last_r[7:0] != CHR_SPACE));
    wr_en   = keep && (cnt_r < CNT_W'(STORE_DEPTH));
    done    = 1'b0;

    if (take) begin
      unique case (item.op)
        OP_START: begin
          busy_nxt    = 1'b1;
          mqtt_nxt    = item.mqtt_mode;
          cnt_nxt     = '0;
          last_nxt    = '0;
          elapsed_nxt = '0;
          limit_nxt   = item.timeout_ticks;
        end
        OP_BYTE: begin
          if (busy_r) begin
            for (int i = 0; i < VIEW_LEN; i++) begin
              if (wr_en && (cnt_r == CNT_W'(i))) begin
                store_nxt[i] = ch;
              end
            end
            if (wr_en) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            if (keep) begin
              last_nxt = {last_r[15:0], ch};
            end
            if (mqtt_r) begin
              done = (cnt_nxt > CNT_W'(10)) && (last_nxt[23:16] == ",") &&
                     (last_nxt[15:8] != 8'h00) && (last_nxt[7:0] == CHR_SPACE);
            end else begin
              done = (cnt_nxt >= CNT_W'(2)) && (last_nxt[15:8] == "O") &&
                     ((last_nxt[7:0] == "K") || (last_nxt[7:0] == "R"));
            end
            if (done) begin
              busy_nxt   = 1'b0;
              res.valid  = 1'b1;
              res.status = classify(view);
            end
          end
        end
        OP_TICK: begin
          if (busy_r) begin
            if (elapsed_r >= limit_r) begin
              busy_nxt   = 1'b0;
              res.valid  = 1'b1;
              res.status = ST_TIMEOUT;
            end else begin
              elapsed_nxt = elapsed_r + TICK_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Mask entries past the reply; in MQTT mode the final space reads as zero.
  always_comb begin
    cnt_lim = mqtt_r ? (cnt_nxt - CNT_W'(1)) : cnt_nxt;
    for (int i = 0; i < VIEW_LEN; i++) begin
      view[i] = (CNT_W'(i) < cnt_lim) ? store_nxt[i] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      mqtt_r    <= 1'b0;
      cnt_r     <= '0;
      last_r    <= '0;
      elapsed_r <= '0;
      limit_r   <= '0;
    end else begin
      busy_r    <= busy_nxt;
      mqtt_r    <= mqtt_nxt;
      cnt_r     <= cnt_nxt;
      last_r    <= last_nxt;
      elapsed_r <= elapsed_nxt;
      limit_r   <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STORE_DEPTH))
    else $error("character count past store depth");

  a_res_idles: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> !busy_r)
    else $error("still busy after a result");

  a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (item.op == OP_TICK) && busy_r && (elapsed_r < limit_r))
    |=> (elapsed_r == $past(elapsed_r) + TICK_W'(1)))
    else $error("tick count did not advance");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import arfc_pkg::*;

  // Op code 3 is not defined; the block must drop it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int ITEM_TARGET    = 1100;  // items that the block acts on
  localparam int TAIL_ITEMS     = 150;   // final stretch run with no idling
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_op;
  logic [7:0]        in_rx_byte;
  logic              in_mqtt_mode;
  logic [TICK_W-1:0] in_timeout_ticks;
  logic              out_valid;
  logic              out_ready = 1'b0;
  status_t           out_status;

  at_response_framer_classifier dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_rx_byte       (in_rx_byte),
    .in_mqtt_mode     (in_mqtt_mode),
    .in_timeout_ticks (in_timeout_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Reply tracker: a second, independent view of the framer. It mirrors the
  // reply buffer, the character count, the last three characters, the tick
  // counter and the open/closed state, and queues the status that each item
  // ought to produce.
  // ---------------------------------------------------------------------------
  logic [7:0]        reply_mem [STORE_DEPTH];
  int unsigned       reply_len;
  logic [23:0]       tail_chars;     // newest character in the low byte
  bit                reply_open;
  bit                mqtt_rule;
  logic [TICK_W-1:0] ticks_seen;
  logic [TICK_W-1:0] ticks_allowed;

  status_t           expected_status [$];
  int                results_predicted;
  int                effective_items;
  int                failures;

  // Shared state of the stimulus side.
  logic [7:0]        reply_text [$];
  bit                calm;           // no sender gaps for the current reply
  bit                tail_phase;     // no idling on either side from here on

  function automatic void clear_reply();
    foreach (reply_mem[i]) reply_mem[i] = 8'h00;
    reply_len  = 0;
    tail_chars = '0;
    ticks_seen = '0;
  endfunction

  // Positions past the buffer read as zero.
  function automatic logic [7:0] char_at(int unsigned pos);
    return (pos < STORE_DEPTH) ? reply_mem[pos] : 8'h00;
  endfunction

  function automatic bit text_is(int unsigned pos, string t);
    for (int k = 0; k < t.len(); k++) begin
      if (char_at(pos + k) != 8'(t[k])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Hold the character if there is room; the tail always moves.
  function automatic void store_char(logic [7:0] c);
    if (reply_len < STORE_DEPTH) begin
      reply_mem[reply_len] = c;
      reply_len++;
    end
    tail_chars = {tail_chars[15:0], c};
  endfunction

  // Frame one received byte; returns 1 when the reply is complete.
  function automatic bit frame_char(logic [7:0] c);
    if (c != CHR_CR && c != CHR_LF) begin
      store_char(c);
    end else if (reply_len != 0 && tail_chars[7:0] != CHR_SPACE) begin
      // Fold a line break into one space, never leading, never doubled.
      store_char(CHR_SPACE);
    end
    if (mqtt_rule) begin
      // Comma, any non-zero character, space: blank out that final space.
      if (reply_len > 10 && tail_chars[23:16] == "," && tail_chars[15:8] != 8'h00 &&
          tail_chars[7:0] == CHR_SPACE) begin
        reply_mem[reply_len - 1] = 8'h00;
        return 1'b1;
      end
      return 1'b0;
    end
    return reply_len >= 2 && tail_chars[15:8] == "O" &&
           (tail_chars[7:0] == "K" || tail_chars[7:0] == "R");
  endfunction

  function automatic status_t grade_reply();
    logic [7:0] a;
    logic [7:0] b;
    status_t    st;
    a = char_at(6);
    b = char_at(7);
    if (char_at(0) == "+") begin
      if (text_is(1, "CPIN")) begin
        st = (char_at(7) == "R") ? ST_OK : ST_ERROR;
      end else if (text_is(1, "CREG")) begin
        st = (char_at(9) == "1") ? ST_OK : ST_ERROR;
      end else if (text_is(1, "CGREG") || text_is(1, "CEREG")) begin
        st = (char_at(10) == "1") ? ST_OK : ST_ERROR;
      end else if (text_is(1, "CSQ")) begin
        if (a == "9" && b == "9") st = ST_NOSIG;
        else if (a <= "1" && b <= "7") st = ST_POOR;
        else if (a >= "3" && b >= "1") st = ST_GREAT;
        else st = ST_GOOD;
      end else if (text_is(1, "CME")) begin
        st = ST_ERROR;
      end else if (text_is(1, "QNWINFO")) begin
        st = ST_OK;
      end else begin
        st = ST_UNKNOWN;
      end
    end else if (text_is(2, " +QMT")) begin
      if (text_is(7, "OPEN") || text_is(7, "DISC")) begin
        st = (char_at(15) == "0") ? ST_OK : ST_ERROR;
      end else if (text_is(7, "CONN")) begin
        st = (char_at(17) == "0") ? ST_OK : ST_ERROR;
      end else if (text_is(7, "SUB") || text_is(7, "UNS") || text_is(7, "PUB")) begin
        st = (char_at(16) != "2") ? ST_OK : ST_ERROR;
      end else begin
        st = ST_UNKNOWN;
      end
    end else if (text_is(0, "OK") || text_is(0, "AT")) begin
      st = ST_OK;
    end else if (text_is(0, "ER")) begin
      st = ST_ERROR;
    end else if (is_numeral(char_at(0)) && is_numeral(char_at(1))) begin
      st = ST_OK;
    end else begin
      st = ST_UNKNOWN;
    end
    return st;
  endfunction

  function automatic void close_reply(status_t st);
    reply_open = 1'b0;
    expected_status.push_back(st);
    results_predicted++;
  endfunction

  // Advance the tracker by one accepted item; flag whether the block acts on it.
  task automatic track_item(input logic [1:0] op, input logic [7:0] c, input logic mqtt,
                            input logic [TICK_W-1:0] limit, output bit acted);
    acted = 1'b0;
    case (op)
      OP_START: begin
        clear_reply();
        reply_open    = 1'b1;
        mqtt_rule     = mqtt;
        ticks_allowed = limit;
        acted         = 1'b1;
      end
      OP_BYTE: begin
        if (reply_open) begin
          acted = 1'b1;
          if (frame_char(c)) close_reply(grade_reply());
        end
      end
      OP_TICK: begin
        if (reply_open) begin
          acted = 1'b1;
          // Time out on the tick after the limit has been used up.
          if (ticks_seen >= ticks_allowed) close_reply(ST_TIMEOUT);
          else ticks_seen++;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one item per call, with an optional gap in front of it. Valid is
  // only lowered for a gap, so back-to-back items keep it high throughout.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [7:0] c, input logic mqtt,
                           input logic [TICK_W-1:0] limit);
    bit acted;
    if (!calm && !tail_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_rx_byte       <= c;
    in_mqtt_mode     <= mqtt;
    in_timeout_ticks <= limit;
    do @(posedge clk); while (!in_ready);
    track_item(op, c, mqtt, limit, acted);
    if (acted) effective_items++;
  endtask

  task automatic send_text(input string t);
    for (int k = 0; k < t.len(); k++) send_item(OP_BYTE, 8'(t[k]), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Reply composition for the random part.
  // ---------------------------------------------------------------------------
  task automatic add_text(input string t);
    for (int k = 0; k < t.len(); k++) reply_text.push_back(8'(t[k]));
  endtask

  // Modems are not consistent about line ends; vary them.
  task automatic add_eol();
    case ($urandom_range(0, 5))
      0: reply_text.push_back(CHR_CR);
      1: reply_text.push_back(CHR_LF);
      2: begin
        reply_text.push_back(CHR_CR);
        reply_text.push_back(CHR_CR);
        reply_text.push_back(CHR_LF);
      end
      default: begin
        reply_text.push_back(CHR_CR);
        reply_text.push_back(CHR_LF);
      end
    endcase
  endtask

  // Finish a plain reply with a blank line and the final OK.
  task automatic add_final_ok();
    add_eol();
    add_eol();
    add_text("OK");
  endtask

  // MQTT replies start with the command's OK, then the unsolicited line.
  task automatic add_urc_lead();
    add_text("OK");
    add_eol();
    add_eol();
  endtask

  // Bias noise towards the characters that drive framing and termination.
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return ",";
      2: return CHR_SPACE;
      3: return CHR_CR;
      4: return CHR_LF;
      5: return "O";
      6: return "K";
      7: return "R";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic compose_reply(output bit mqtt);
    string tag;
    int    n;
    mqtt = 1'b0;
    case ($urandom_range(0, 16))
      0: add_text("OK");
      1: begin
        add_text("AT+COPS?");
        add_eol();
        add_eol();
        add_text("ERROR");
      end
      2: begin
        n = ($urandom_range(0, 2) == 0) ? 99 : $urandom_range(0, 40);
        add_text($sformatf("+CSQ: %0d,99", n));
        add_final_ok();
      end
      3: begin
        if ($urandom_range(0, 1) == 0) tag = "READY";
        else tag = "SIM PIN";
        add_text({"+CPIN: ", tag});
        add_final_ok();
      end
      4: begin
        add_text($sformatf("+CREG: 0,%0d", $urandom_range(0, 5)));
        add_final_ok();
      end
      5: begin
        tag = ($urandom_range(0, 1) == 0) ? "CGREG" : "CEREG";
        add_text($sformatf("+%s: 0,%0d", tag, $urandom_range(0, 5)));
        add_final_ok();
      end
      6: add_text($sformatf("+CME ERROR: %0d", $urandom_range(0, 99)));
      7: begin
        add_text("+QNWINFO: \"FDD LTE\",\"46000\",\"LTE BAND 3\",1650");
        add_final_ok();
      end
      8: begin
        // Serial number, with or without the command echo in front.
        if ($urandom_range(0, 1) == 0) begin
          add_text("AT+GSN");
          add_eol();
        end
        add_text($sformatf("%0d", $urandom_range(10000000, 99999999)));
        add_final_ok();
      end
      9: begin
        case ($urandom_range(0, 2))
          0: add_text("HELLO");
          1: add_text("+XYZ: 1");
          default: add_text("NO CARRIER");
        endcase
        add_final_ok();
      end
      10: begin
        // Long enough to run past the classified view of the reply.
        n = $urandom_range(20, 40);
        repeat (n) reply_text.push_back(8'($urandom_range(33, 126)));
        add_final_ok();
      end
      11: begin
        n = $urandom_range(1, 30);
        repeat (n) reply_text.push_back(pick_noise());
        if ($urandom_range(0, 1) == 0) add_text("OK");
      end
      12: begin
        mqtt = 1'b1;
        tag  = ($urandom_range(0, 1) == 0) ? "OPEN" : "DISC";
        add_urc_lead();
        add_text($sformatf("+QMT%s: 0,%0d", tag, $urandom_range(0, 3)));
        add_eol();
      end
      13: begin
        mqtt = 1'b1;
        add_urc_lead();
        add_text($sformatf("+QMTCONN: 0,%0d,%0d", $urandom_range(0, 1), $urandom_range(0, 5)));
        add_eol();
      end
      14: begin
        mqtt = 1'b1;
        case ($urandom_range(0, 2))
          0: tag = "SUB";
          1: tag = "UNS";
          default: tag = "PUB";
        endcase
        add_urc_lead();
        add_text($sformatf("+QMT%s: 0,%0d,%0d", tag, $urandom_range(1, 9), $urandom_range(0, 2)));
        add_eol();
      end
      15: begin
        // Unknown MQTT line, sometimes without the leading OK.
        mqtt = 1'b1;
        if ($urandom_range(0, 1) == 0) add_urc_lead();
        add_text($sformatf("+QMTSTAT: 0,%0d", $urandom_range(0, 9)));
        add_eol();
      end
      default: begin
        mqtt = 1'b1;
        n    = $urandom_range(5, 40);
        repeat (n) reply_text.push_back(pick_noise());
      end
    endcase
  endtask

  // One start item, then the reply bytes with ticks interleaved.
  task automatic send_reply();
    bit                mqtt;
    bit                tick_heavy;
    logic [TICK_W-1:0] limit;
    calm = $urandom_range(0, 3) == 0;
    reply_text.delete();
    compose_reply(mqtt);
    // Break a few replies by overwriting one character.
    if ($urandom_range(0, 9) == 0)
      reply_text[$urandom_range(0, reply_text.size() - 1)] = pick_noise();
    tick_heavy = $urandom_range(0, 5) == 0;
    if (tick_heavy) limit = TICK_W'($urandom_range(0, 6));
    else if ($urandom_range(0, 19) == 0) limit = '1;
    else limit = TICK_W'($urandom);
    send_item(OP_START, 8'($urandom), mqtt, limit);
    foreach (reply_text[i]) begin
      if ($urandom_range(0, tick_heavy ? 2 : 19) == 0)
        send_item(OP_TICK, 8'($urandom), 1'($urandom), TICK_W'($urandom));
      if (!reply_open) break;
      send_item(OP_BYTE, reply_text[i], 1'($urandom), TICK_W'($urandom));
      if (!reply_open) break;
    end
    // With a short limit, ticks are sent until the reply closes, by its end or by timeout.
    while (tick_heavy && reply_open)
      send_item(OP_TICK, 8'($urandom), 1'($urandom), TICK_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes, ticks and the undefined op while no reply is open: drop them all.
  task automatic test_ignored_while_idle();
    send_item(OP_BYTE, "O", 1'b1, '1);
    send_item(OP_BYTE, "K", 1'b0, '0);
    send_item(OP_TICK, 8'hFF, 1'b1, '1);
    send_item(OP_UNUSED, 8'hFF, 1'b1, '1);
  endtask

  // Leading line breaks are dropped, then OK closes the reply.
  task automatic test_plain_ok_reply();
    send_item(OP_START, 8'h00, 1'b0, '1);
    send_item(OP_BYTE, CHR_CR, 1'b0, '0);
    send_item(OP_BYTE, CHR_LF, 1'b0, '0);
    send_text("OK");
  endtask

  // A second start abandons the open reply without a result.
  task automatic test_restart_in_reply();
    send_item(OP_START, 8'h00, 1'b1, '0);
    send_text("E");
    send_item(OP_START, 8'hFF, 1'b0, '1);
    send_text("EROR");
  endtask

  // Limit zero times out on the first tick; op 3 mid-reply changes nothing.
  task automatic test_tick_timeout();
    send_item(OP_START, 8'h00, 1'b0, '0);
    send_item(OP_TICK, 8'h00, 1'b0, '0);
    send_item(OP_START, 8'h00, 1'b1, TICK_W'(1));
    send_item(OP_UNUSED, 8'h00, 1'b0, '0);
    send_item(OP_TICK, 8'h00, 1'b0, '0);
    send_item(OP_TICK, 8'h00, 1'b0, '0);
  endtask

  task automatic test_random_replies();
    while (effective_items < ITEM_TARGET) begin
      if (effective_items >= ITEM_TARGET - TAIL_ITEMS) tail_phase = 1'b1;
      if ($urandom_range(0, 11) == 0)
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), TICK_W'($urandom));
      else
        send_reply();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, then the status check.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (tail_phase) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic log_fault(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        log_fault($sformatf("status %0d with no reply pending", out_status));
      end else begin
        want = expected_status.pop_front();
        if (out_status !== want)
          log_fault($sformatf("status expected %0d (%s), actual %0d",
                              want, want.name(), out_status));
      end
    end
  end

  // Watchdog: too long with no item moving on either channel.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_op            <= OP_START;
    in_rx_byte       <= 8'h00;
    in_mqtt_mode     <= 1'b0;
    in_timeout_ticks <= '0;
    clear_reply();
    reply_open        = 1'b0;
    mqtt_rule         = 1'b0;
    ticks_allowed     = '0;
    results_predicted = 0;
    effective_items   = 0;
    failures          = 0;
    calm              = 1'b0;
    tail_phase        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_ignored_while_idle();
    test_plain_ok_reply();
    test_restart_in_reply();
    test_tick_timeout();
    test_random_replies();

    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && expected_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
